>>> rtl/core/segx_pkg.sv
// ----------------------------------------------------------------------------
// segx_pkg
// shared types and widths for the segment intersection pipeline
// ----------------------------------------------------------------------------
package segx_pkg;

  localparam int COORD_W   = 32;                 // q16.16 coordinate
  localparam int DIFF_W    = COORD_W + 1;        // coordinate difference
  localparam int PROD_W    = 2 * DIFF_W;         // product of two differences
  localparam int SUM_W     = PROD_W + 1;         // determinant and numerators
  localparam int MAG_W     = 2 * COORD_W + 1;    // |det| and |n1| on a hit
  localparam int QUOT_W    = COORD_W;            // offset along the test segment
  localparam int DIVD_W    = MAG_W + QUOT_W;     // dividend |n1| * |d|
  localparam int LO_W      = MAG_W - COORD_W;    // low slice of |n1|
  localparam int DIV_STEPS = QUOT_W;             // one quotient bit per stage

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] test_start_r;
    logic signed [COORD_W-1:0] test_start_z;
    logic signed [COORD_W-1:0] test_end_r;
    logic signed [COORD_W-1:0] test_end_z;
    logic signed [COORD_W-1:0] bound_start_r;
    logic signed [COORD_W-1:0] bound_start_z;
    logic signed [COORD_W-1:0] bound_end_r;
    logic signed [COORD_W-1:0] bound_end_z;
  } seg_in_t;

  typedef struct packed {
    logic                      crosses;
    logic signed [COORD_W-1:0] point_r;
    logic signed [COORD_W-1:0] point_z;
  } seg_out_t;

  // side data carried along the determinant stages
  typedef struct packed {
    logic [COORD_W-1:0] start_r;
    logic [COORD_W-1:0] start_z;
    logic [COORD_W-1:0] end_r;
    logic [COORD_W-1:0] end_z;
    logic [COORD_W-1:0] mr;
    logic [COORD_W-1:0] mz;
    logic               dr_neg;
    logic               dz_neg;
  } seg_pass_t;

  // decision and magnitudes handed to the scaling stages
  typedef struct packed {
    logic               hit;
    logic               neg_r;
    logic               neg_z;
    logic [COORD_W-1:0] start_r;
    logic [COORD_W-1:0] start_z;
    logic [COORD_W-1:0] end_r;
    logic [COORD_W-1:0] end_z;
    logic [MAG_W-1:0]   an;
    logic [MAG_W-1:0]   ad;
    logic [COORD_W-1:0] mr;
    logic [COORD_W-1:0] mz;
  } seg_frac_t;

  // state of the restoring divider, one per stage
  typedef struct packed {
    logic               hit;
    logic               neg_r;
    logic               neg_z;
    logic [COORD_W-1:0] start_r;
    logic [COORD_W-1:0] start_z;
    logic [COORD_W-1:0] end_r;
    logic [COORD_W-1:0] end_z;
    logic [MAG_W-1:0]   ad;
    logic [DIVD_W-1:0]  dsh;
    logic [DIVD_W-1:0]  rem_r;
    logic [DIVD_W-1:0]  rem_z;
    logic [QUOT_W-1:0]  q_r;
    logic [QUOT_W-1:0]  q_z;
  } seg_div_t;

endpackage

>>> rtl/core/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// parametric crossing test of a test segment against a boundary segment
// ----------------------------------------------------------------------------
//  channel  | ports                              | payload
//  ---------+------------------------------------+---------------------------
//  input    | in_valid, in_ready, in_data        | seg_in_t, eight q16.16
//  result   | out_valid, out_ready, out_data     | seg_out_t, hit + point
//
//  one item per cycle sustained while out_ready stays high
//  the divider gives one quotient bit per stage, 32 stages
//  rst_n is synchronous, active low, and clears only the valid bits
//  every stage has its own valid bit and loads when empty or when the next
//  stage moves, so bubbles close up and a stall drops or repeats no item
// ----------------------------------------------------------------------------
module segment_intersection import segx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  seg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output seg_out_t out_data
);

  // determinant stages to scaling stages
  logic      fr_valid, fr_ready;
  seg_frac_t fr_data;

  // divider chain, entry 0 is the scaling output
  logic      div_v   [DIV_STEPS+1];
  logic      div_rdy [DIV_STEPS+1];
  seg_div_t  div_d   [DIV_STEPS+1];

  seg_div_t  fin;
  logic      fin_ready;
  logic      out_valid_r;
  seg_out_t  out_data_r, out_nxt;

  segx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  segx_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (div_v[0]),
    .out_ready (div_rdy[0]),
    .out_data  (div_d[0])
  );

  // restoring divider, msb of the quotient first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    segx_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[i]),
      .in_ready  (div_rdy[i]),
      .in_data   (div_d[i]),
      .out_valid (div_v[i+1]),
      .out_ready (div_rdy[i+1]),
      .out_data  (div_d[i+1])
    );
  end

  assign fin                = div_d[DIV_STEPS];
  assign fin_ready          = !out_valid_r || out_ready;
  assign div_rdy[DIV_STEPS] = fin_ready;

  // start +/- offset with clamp to the coordinate range
  function automatic logic [COORD_W-1:0] place(logic [COORD_W-1:0] start,
                                               logic [QUOT_W-1:0]  off,
                                               logic               neg);
    logic signed [COORD_W+1:0] s;
    logic signed [COORD_W+1:0] o;
    logic signed [COORD_W+1:0] p;
    s = $signed({{2{start[COORD_W-1]}}, start});
    o = $signed({2'b00, off});
    p = neg ? (s - o) : (s + o);
    if (p[COORD_W+1:COORD_W-1] == 3'b000 || p[COORD_W+1:COORD_W-1] == 3'b111) begin
      return p[COORD_W-1:0];
    end
    return p[COORD_W+1] ? COORD_MIN : COORD_MAX;
  endfunction

  always_comb begin
    out_nxt.crosses = fin.hit;
    out_nxt.point_r = fin.hit ? place(fin.start_r, fin.q_r, fin.neg_r) : fin.end_r;
    out_nxt.point_z = fin.hit ? place(fin.start_z, fin.q_z, fin.neg_z) : fin.end_z;
  end

  // output register, the last pipeline stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= div_v[DIV_STEPS];
    end
    if (fin_ready) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a hit means |n1| never exceeds |det|, so the quotient fits
  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid && fr_data.hit |-> fr_data.an <= fr_data.ad)
    else $error("hit with |n1| above |det|");

  // the divider's final remainder stays below the divisor
  a_rem_r: assert property (@(posedge clk) disable iff (!rst_n)
    div_v[DIV_STEPS] && fin.hit |-> (fin.rem_r < DIVD_W'(fin.ad)) &&
                                    (fin.rem_z < DIVD_W'(fin.ad)))
    else $error("divider remainder not reduced");

  // a stalled result register keeps its item while the pipe behind fills
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result lost during stall");

endmodule

>>> rtl/core/segx_front.sv
// ----------------------------------------------------------------------------
// segx_front
// differences, cross products, determinant and hit decision (four stages)
// ----------------------------------------------------------------------------
module segx_front import segx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  seg_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output seg_frac_t out_data
);

  function automatic logic signed [DIFF_W-1:0] sub_ext(logic [COORD_W-1:0] a,
                                                       logic [COORD_W-1:0] b);
    return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  function automatic logic [COORD_W-1:0] mag_of(logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    return m[COORD_W-1:0];
  endfunction

  // 0 <= n/d <= 1, exact
  function automatic logic in_unit(logic signed [SUM_W-1:0] n,
                                   logic signed [SUM_W-1:0] d);
    if (d[SUM_W-1]) begin
      return (n[SUM_W-1] || (n == '0)) && (n >= d);
    end
    return !n[SUM_W-1] && (n <= d);
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic signed [DIFF_W-1:0] dr_r, dz_r, bdr_r, bdz_r, sr_r, sz_r;
  logic signed [DIFF_W-1:0] dr_nxt, dz_nxt;
  seg_pass_t                p1_r, p2_r, p3_r, p1_nxt;

  logic signed [PROD_W-1:0] drbdz_r, dzbdr_r, srbdz_r, szbdr_r, drsz_r, dzsr_r;
  logic signed [SUM_W-1:0]  det_r, n1_r, n2_r;
  seg_frac_t                out_r, out_nxt;

  logic [SUM_W-1:0] an_w, ad_w;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign dr_nxt = sub_ext(in_data.test_end_r, in_data.test_start_r);
  assign dz_nxt = sub_ext(in_data.test_end_z, in_data.test_start_z);

  always_comb begin
    p1_nxt.start_r = in_data.test_start_r;
    p1_nxt.start_z = in_data.test_start_z;
    p1_nxt.end_r   = in_data.test_end_r;
    p1_nxt.end_z   = in_data.test_end_z;
    p1_nxt.mr      = mag_of(dr_nxt);
    p1_nxt.mz      = mag_of(dz_nxt);
    p1_nxt.dr_neg  = dr_nxt[DIFF_W-1];
    p1_nxt.dz_neg  = dz_nxt[DIFF_W-1];
  end

  // magnitudes and sign of the offset for the last stage
  assign an_w = n1_r[SUM_W-1]  ? (~n1_r + SUM_W'(1))  : n1_r;
  assign ad_w = det_r[SUM_W-1] ? (~det_r + SUM_W'(1)) : det_r;

  always_comb begin
    out_nxt.hit     = (det_r != '0) && in_unit(n1_r, det_r) && in_unit(n2_r, det_r);
    out_nxt.neg_r   = p3_r.dr_neg ^ n1_r[SUM_W-1] ^ det_r[SUM_W-1];
    out_nxt.neg_z   = p3_r.dz_neg ^ n1_r[SUM_W-1] ^ det_r[SUM_W-1];
    out_nxt.start_r = p3_r.start_r;
    out_nxt.start_z = p3_r.start_z;
    out_nxt.end_r   = p3_r.end_r;
    out_nxt.end_z   = p3_r.end_z;
    out_nxt.an      = an_w[MAG_W-1:0];
    out_nxt.ad      = ad_w[MAG_W-1:0];
    out_nxt.mr      = p3_r.mr;
    out_nxt.mz      = p3_r.mz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
    if (en1) begin
      dr_r  <= dr_nxt;
      dz_r  <= dz_nxt;
      bdr_r <= sub_ext(in_data.bound_end_r, in_data.bound_start_r);
      bdz_r <= sub_ext(in_data.bound_end_z, in_data.bound_start_z);
      sr_r  <= sub_ext(in_data.bound_start_r, in_data.test_start_r);
      sz_r  <= sub_ext(in_data.bound_start_z, in_data.test_start_z);
      p1_r  <= p1_nxt;
    end
    if (en2) begin
      drbdz_r <= dr_r * bdz_r;
      dzbdr_r <= dz_r * bdr_r;
      srbdz_r <= sr_r * bdz_r;
      szbdr_r <= sz_r * bdr_r;
      drsz_r  <= dr_r * sz_r;
      dzsr_r  <= dz_r * sr_r;
      p2_r    <= p1_r;
    end
    if (en3) begin
      det_r <= $signed({dzbdr_r[PROD_W-1], dzbdr_r}) - $signed({drbdz_r[PROD_W-1], drbdz_r});
      n1_r  <= $signed({szbdr_r[PROD_W-1], szbdr_r}) - $signed({srbdz_r[PROD_W-1], srbdz_r});
      n2_r  <= $signed({drsz_r[PROD_W-1], drsz_r}) - $signed({dzsr_r[PROD_W-1], dzsr_r});
      p3_r  <= p2_r;
    end
    if (en4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/segx_scale.sv
// ----------------------------------------------------------------------------
// segx_scale
// forms the dividend |n1| * |d| for both coordinates (two stages)
// ----------------------------------------------------------------------------
module segx_scale import segx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  seg_frac_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output seg_div_t  out_data
);

  logic v1_r, v2_r;
  logic en1, en2;

  // partial products, low slice 33x32 and high slice 32x32
  logic [MAG_W-1:0]       lo_rc_r, lo_zc_r;
  logic [2*COORD_W-1:0]   hi_rc_r, hi_zc_r;
  seg_frac_t              f_r;
  seg_div_t               out_r, out_nxt;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    out_nxt.hit     = f_r.hit;
    out_nxt.neg_r   = f_r.neg_r;
    out_nxt.neg_z   = f_r.neg_z;
    out_nxt.start_r = f_r.start_r;
    out_nxt.start_z = f_r.start_z;
    out_nxt.end_r   = f_r.end_r;
    out_nxt.end_z   = f_r.end_z;
    out_nxt.ad      = f_r.ad;
    out_nxt.dsh     = {1'b0, f_r.ad, {(QUOT_W-1){1'b0}}};
    out_nxt.rem_r   = {hi_rc_r, {LO_W{1'b0}}} + DIVD_W'(lo_rc_r);
    out_nxt.rem_z   = {hi_zc_r, {LO_W{1'b0}}} + DIVD_W'(lo_zc_r);
    out_nxt.q_r     = '0;
    out_nxt.q_z     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
    if (en1) begin
      lo_rc_r <= in_data.an[LO_W-1:0] * in_data.mr;
      lo_zc_r <= in_data.an[LO_W-1:0] * in_data.mz;
      hi_rc_r <= in_data.an[MAG_W-1:LO_W] * in_data.mr;
      hi_zc_r <= in_data.an[MAG_W-1:LO_W] * in_data.mz;
      f_r     <= in_data;
    end
    if (en2) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/segx_div_step.sv
// ----------------------------------------------------------------------------
// segx_div_step
// one restoring division stage, one quotient bit for each coordinate
// ----------------------------------------------------------------------------
module segx_div_step import segx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  seg_div_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output seg_div_t out_data
);

  logic     v_r;
  logic     en;
  logic     ge_r, ge_z;
  seg_div_t d_r, d_nxt;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  assign ge_r = in_data.rem_r >= in_data.dsh;
  assign ge_z = in_data.rem_z >= in_data.dsh;

  always_comb begin
    d_nxt       = in_data;
    d_nxt.rem_r = ge_r ? (in_data.rem_r - in_data.dsh) : in_data.rem_r;
    d_nxt.rem_z = ge_z ? (in_data.rem_z - in_data.dsh) : in_data.rem_z;
    d_nxt.q_r   = {in_data.q_r[QUOT_W-2:0], ge_r};
    d_nxt.q_z   = {in_data.q_z[QUOT_W-2:0], ge_z};
    d_nxt.dsh   = in_data.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule
